@@ src/ipbd_pkg.sv @@
// shared types and constants for the input packet bitstream decoder
package ipbd_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 16384;
    localparam int unsigned HDR_BYTES        = 32;
    localparam int unsigned Q_DEPTH          = 4;
    localparam int unsigned Q_PTR_W          = $clog2(Q_DEPTH);

    localparam logic [7:0]  WANTED_TYPE  = 8'd3;
    localparam logic [15:0] POS_TYPE     = 16'd4;
    localparam logic [15:0] POS_SF0      = 16'd21;
    localparam logic [15:0] POS_SF1      = 16'd22;
    localparam logic [15:0] POS_SF2      = 16'd23;
    localparam logic [15:0] POS_SF3      = 16'd24;
    localparam logic [15:0] POS_BT_LO    = 16'd29;
    localparam logic [15:0] POS_BT_HI    = 16'd30;
    localparam logic [16:0] RECORD_BITS  = 17'd9;

    localparam logic RK_FRAME   = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    typedef enum logic [3:0] {
        K_NONE    = 4'd0,
        K_TYPE    = 4'd1,
        K_SF0     = 4'd2,
        K_SF1     = 4'd3,
        K_SF2     = 4'd4,
        K_SF3     = 4'd5,
        K_BT_LO   = 4'd6,
        K_BT_HI   = 4'd7,
        K_PAYLOAD = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        PH_CONT = 3'b001,
        PH_ON   = 3'b010,
        PH_BTN  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        t_kind       kind;
        logic [15:0] len;
    } t_entry;

endpackage

@@ src/ipbd_if.sv @@
// channel interfaces: byte input, result output and configuration write
interface ipbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipbd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] frame_number;
    logic [31:0] pressed_mask;
    logic        pass_through;
    logic        last_result;
    modport source (output valid, output result_kind, output frame_number,
                    output pressed_mask, output pass_through, output last_result,
                    input ready);
    modport sink (input valid, input result_kind, input frame_number,
                  input pressed_mask, input pass_through, input last_result,
                  output ready);
endinterface

interface ipbd_cfg_if;
    logic valid;
    logic ready;
    logic gate_enabled;
    modport source (output valid, output gate_enabled, input ready);
    modport sink (input valid, input gate_enabled, output ready);
endinterface

@@ src/ipbd_front.sv @@
// front end: byte position tracking and byte classification
module ipbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipbd_in_if.sink           i_in,
    input  logic              i_q_ready,
    output logic              o_push,
    output ipbd_pkg::t_entry  o_entry
);
    import ipbd_pkg::*;

    logic [15:0] r_pos;
    logic [15:0] n_pos;
    logic [15:0] len;
    logic        in_range;
    t_kind       kind;

    assign in_range    = r_pos < 16'(MAX_PACKET_BYTES);
    assign len         = in_range ? r_pos + 16'd1 : r_pos;
    assign i_in.ready  = i_q_ready;
    assign o_push      = i_in.valid && i_q_ready;

    always_comb begin
        kind = K_NONE;
        if (in_range) begin
            if (r_pos == POS_TYPE) begin
                kind = K_TYPE;
            end else if (r_pos == POS_SF0) begin
                kind = K_SF0;
            end else if (r_pos == POS_SF1) begin
                kind = K_SF1;
            end else if (r_pos == POS_SF2) begin
                kind = K_SF2;
            end else if (r_pos == POS_SF3) begin
                kind = K_SF3;
            end else if (r_pos == POS_BT_LO) begin
                kind = K_BT_LO;
            end else if (r_pos == POS_BT_HI) begin
                kind = K_BT_HI;
            end else if (r_pos >= 16'(HDR_BYTES)) begin
                kind = K_PAYLOAD;
            end
        end
    end

    assign o_entry.data = i_in.data_byte;
    assign o_entry.last = i_in.last_byte;
    assign o_entry.kind = kind;
    assign o_entry.len  = len;

    assign n_pos = o_push ? (i_in.last_byte ? 16'd0 : len) : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 16'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ src/ipbd_fifo.sv @@
// short queue between front and back
module ipbd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ipbd_pkg::t_entry  i_entry,
    output logic              o_ready,
    output logic              o_valid,
    output ipbd_pkg::t_entry  o_entry,
    input  logic              i_pop
);
    import ipbd_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_PTR_W:0]     r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_ready = r_cnt < (Q_PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
        end
    end

endmodule

@@ src/ipbd_back.sv @@
// back end: header capture, bit-serial record decode, verdict and output register
module ipbd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ipbd_pkg::t_entry  i_entry,
    output logic              o_pop,
    ipbd_cfg_if.sink          i_cfg,
    ipbd_out_if.source        o_out
);
    import ipbd_pkg::*;

    // packet state
    logic        r_gate, n_gate;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_sf, n_sf;
    logic [15:0] r_bt, n_bt;
    logic [15:0] r_off, n_off;
    logic [31:0] r_fc, n_fc;
    logic [31:0] r_acc, n_acc;
    t_phase      r_phase, n_phase;
    logic        r_on, n_on;
    logic [7:0]  r_btn, n_btn;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_malf, n_malf;
    logic        r_done, n_done;
    logic [2:0]  r_idx, n_idx;
    logic        r_verdict, n_verdict;

    // output register
    logic        r_ov, n_ov;
    logic        r_kind, n_kind;
    logic [31:0] r_fn, n_fn;
    logic [31:0] r_mask, n_mask;
    logic        r_pass, n_pass;
    logic        r_last, n_last;

    logic        step;
    logic        fin;
    logic        pop;
    logic [7:0]  shifted;
    logic        cur_bit;
    logic        nxt_bit;
    logic [15:0] off_n;
    logic [7:0]  btn_n;
    logic        more;
    logic [15:0] len_m;
    logic        pass;

    assign step    = i_valid && (!r_ov || o_out.ready);
    assign shifted = i_entry.data >> r_idx;
    assign cur_bit = shifted[0];
    assign nxt_bit = shifted[1];
    assign off_n   = r_off + 16'd1;
    assign btn_n   = r_btn | (8'(cur_bit) << r_cnt);
    assign more    = (r_idx != 3'd7) && (off_n < r_bt) && !nxt_bit;
    assign len_m   = i_entry.len - 16'(HDR_BYTES);
    assign pass    = !r_gate || (i_entry.len < 16'(HDR_BYTES)) || (r_type != WANTED_TYPE)
                     || (r_bt == 16'd0) || ({3'b000, r_bt} > {len_m, 3'b000}) || r_malf;

    assign i_cfg.ready = 1'b1;
    assign n_gate      = i_cfg.valid ? i_cfg.gate_enabled : r_gate;

    always_comb begin
        n_type    = r_type;
        n_sf      = r_sf;
        n_bt      = r_bt;
        n_off     = r_off;
        n_fc      = r_fc;
        n_acc     = r_acc;
        n_phase   = r_phase;
        n_on      = r_on;
        n_btn     = r_btn;
        n_cnt     = r_cnt;
        n_malf    = r_malf;
        n_done    = r_done;
        n_idx     = r_idx;
        n_verdict = r_verdict;
        n_ov      = r_ov && !o_out.ready;
        n_kind    = r_kind;
        n_fn      = r_fn;
        n_mask    = r_mask;
        n_pass    = r_pass;
        n_last    = r_last;
        fin       = 1'b0;
        pop       = 1'b0;
        if (step) begin
            if (r_verdict) begin
                n_ov      = 1'b1;
                n_kind    = RK_VERDICT;
                n_fn      = 32'd0;
                n_mask    = 32'd0;
                n_pass    = pass;
                n_last    = 1'b1;
                n_type    = 8'd0;
                n_sf      = 32'd0;
                n_bt      = 16'd0;
                n_off     = 16'd0;
                n_fc      = 32'd0;
                n_acc     = 32'd0;
                n_phase   = PH_CONT;
                n_on      = 1'b0;
                n_btn     = 8'd0;
                n_cnt     = 3'd0;
                n_malf    = 1'b0;
                n_done    = 1'b0;
                n_idx     = 3'd0;
                n_verdict = 1'b0;
                pop       = 1'b1;
            end else begin
                unique case (i_entry.kind)
                    K_TYPE: begin
                        n_type = i_entry.data;
                        fin    = 1'b1;
                    end
                    K_SF0: begin
                        n_sf[7:0] = r_sf[7:0] | i_entry.data;
                        fin       = 1'b1;
                    end
                    K_SF1: begin
                        n_sf[15:8] = r_sf[15:8] | i_entry.data;
                        fin        = 1'b1;
                    end
                    K_SF2: begin
                        n_sf[23:16] = r_sf[23:16] | i_entry.data;
                        fin         = 1'b1;
                    end
                    K_SF3: begin
                        n_sf[31:24] = r_sf[31:24] | i_entry.data;
                        fin         = 1'b1;
                    end
                    K_BT_LO: begin
                        n_bt[7:0] = i_entry.data;
                        fin       = 1'b1;
                    end
                    K_BT_HI: begin
                        n_bt[15:8] = i_entry.data;
                        fin        = 1'b1;
                    end
                    K_PAYLOAD: begin
                        if ((r_type != WANTED_TYPE) || r_done || (r_off >= r_bt)) begin
                            fin = 1'b1;
                        end else begin
                            n_off = off_n;
                            unique case (r_phase)
                                PH_CONT: begin
                                    if (cur_bit) begin
                                        if (({1'b0, off_n} + RECORD_BITS) > {1'b0, r_bt}) begin
                                            n_malf = 1'b1;
                                            n_done = 1'b1;
                                        end else begin
                                            n_phase = PH_ON;
                                        end
                                    end else begin
                                        n_ov   = 1'b1;
                                        n_kind = RK_FRAME;
                                        n_fn   = r_sf + r_fc;
                                        n_mask = r_acc;
                                        n_pass = 1'b0;
                                        n_last = !more && !i_entry.last;
                                        n_fc   = r_fc + 32'd1;
                                        n_acc  = 32'd0;
                                        if (off_n >= r_bt) begin
                                            n_done = 1'b1;
                                        end
                                    end
                                end
                                PH_ON: begin
                                    n_on    = cur_bit;
                                    n_btn   = 8'd0;
                                    n_cnt   = 3'd0;
                                    n_phase = PH_BTN;
                                end
                                PH_BTN: begin
                                    n_btn = btn_n;
                                    n_cnt = r_cnt + 3'd1;
                                    if (r_cnt == 3'd7) begin
                                        if (r_on && (btn_n < 8'd32)) begin
                                            n_acc = r_acc | (32'd1 << btn_n[4:0]);
                                        end
                                        n_phase = PH_CONT;
                                        if (off_n >= r_bt) begin
                                            n_malf = 1'b1;
                                            n_done = 1'b1;
                                        end
                                    end
                                end
                                default: begin
                                    n_phase = PH_CONT;
                                end
                            endcase
                            if ((r_idx != 3'd7) && !n_done && (off_n < r_bt)) begin
                                n_idx = r_idx + 3'd1;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
                if (fin) begin
                    n_idx = 3'd0;
                    if (i_entry.last) begin
                        n_verdict = 1'b1;
                    end else begin
                        pop = 1'b1;
                    end
                end
            end
        end
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate    <= 1'b0;
            r_type    <= 8'd0;
            r_sf      <= 32'd0;
            r_bt      <= 16'd0;
            r_off     <= 16'd0;
            r_fc      <= 32'd0;
            r_acc     <= 32'd0;
            r_phase   <= PH_CONT;
            r_on      <= 1'b0;
            r_btn     <= 8'd0;
            r_cnt     <= 3'd0;
            r_malf    <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= 3'd0;
            r_verdict <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_gate    <= n_gate;
            r_type    <= n_type;
            r_sf      <= n_sf;
            r_bt      <= n_bt;
            r_off     <= n_off;
            r_fc      <= n_fc;
            r_acc     <= n_acc;
            r_phase   <= n_phase;
            r_on      <= n_on;
            r_btn     <= n_btn;
            r_cnt     <= n_cnt;
            r_malf    <= n_malf;
            r_done    <= n_done;
            r_idx     <= n_idx;
            r_verdict <= n_verdict;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_fn   <= n_fn;
        r_mask <= n_mask;
        r_pass <= n_pass;
        r_last <= n_last;
    end

    assign o_out.valid        = r_ov;
    assign o_out.result_kind  = r_kind;
    assign o_out.frame_number = r_fn;
    assign o_out.pressed_mask = r_mask;
    assign o_out.pass_through = r_pass;
    assign o_out.last_result  = r_last;

endmodule

@@ src/input_packet_bitstream_decoder_top.sv @@
// top level of the input packet bitstream decoder
// path: a byte is written into the queue, then decoded from its head into the output register
// header bytes: one step; payload bytes: one step per bit (up to 8); a stalled output holds steps
// a packet's last byte takes one more step for its verdict; the bit-serial back end sets the rate
// a 4-entry queue lets the front keep taking bytes while the back end decodes or the output stalls
// synchronous active-low reset clears all packet state, the queue and the gate register
module input_packet_bitstream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipbd_in_if.sink     i_in,
    ipbd_cfg_if.sink    i_cfg,
    ipbd_out_if.source  o_out
);
    import ipbd_pkg::*;

    logic   push;
    logic   q_ready;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry head_entry;

    ipbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    ipbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (pop)
    );

    ipbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (head_entry),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

    a_verdict_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_kind == RK_VERDICT) |-> o_out.last_result)
        else $error("verdict not marked last");

    a_frame_not_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_kind == RK_FRAME) |-> !o_out.pass_through)
        else $error("frame record carries pass-through");

    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_kind == RK_VERDICT)
        |-> (o_out.frame_number == 32'd0) && (o_out.pressed_mask == 32'd0))
        else $error("verdict carries frame data");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
